@@ hw/rtl/r2b_pkg.sv @@
// ----------------------------------------------------------------------------
// r2b_pkg
// Shared constants, the pipeline payload type and bit-length helpers for the
// rational to binary64 rounder.
// ----------------------------------------------------------------------------
package r2b_pkg;

  localparam int NUM_W      = 96;   // numerator width
  localparam int DEN_W      = 63;   // denominator width
  localparam int NLEN_W     = 7;    // holds 0..NUM_W
  localparam int DLEN_W     = 6;    // holds 0..DEN_W
  localparam int SIG_W      = 53;   // significand with hidden bit
  localparam int QB_W       = SIG_W + 1;  // significand plus round bit
  localparam int STEPS      = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES = QB_W / STEPS;
  localparam int EXP_W      = 9;    // signed unbiased exponent
  localparam int EXPF_W     = 11;   // biased exponent field
  localparam int EXP_BIAS   = 1023;
  localparam int RES_W      = 63;
  localparam int LATENCY    = DIV_STAGES + 3;

  typedef struct packed {
    logic [DEN_W-1:0]        rem;    // partial remainder, below div
    logic [DEN_W-1:0]        div;    // normalized divisor
    logic [QB_W-1:0]         feed;   // dividend bits still to bring down
    logic [QB_W-1:0]         quo;    // quotient bits so far
    logic signed [EXP_W-1:0] expo;
    logic                    zero;   // numerator is zero
    logic                    fail;   // denominator is zero
  } div_t;

  function automatic logic [NLEN_W-1:0] len_num(input logic [NUM_W-1:0] v);
    logic [NLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (v[i]) n = NLEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [DLEN_W-1:0] len_den(input logic [DEN_W-1:0] v);
    logic [DLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < DEN_W; i++) begin
      if (v[i]) n = DLEN_W'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/rational_to_binary64_rounder_unit.sv @@
// ----------------------------------------------------------------------------
// rational_to_binary64_rounder_unit
// Unsigned rational to binary64, round to nearest with ties to even.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_numerator_low/high and in_denominator and raise start; the item
//   transfers on any edge with start high and busy low. busy is always low:
//   the block is a fully pipelined datapath and takes one item every cycle.
//   Each result appears for one cycle with out_valid high once its transfer
//   has passed two front stages for bit lengths and normalization, 27
//   divider stages of two quotient bits each and one rounding stage. Results
//   leave in input order. Throughput is one item per cycle.
//   out_failed marks a zero denominator, with out_result_bits zero. A zero
//   numerator gives +0.
//   Synchronous reset clears every valid bit; items in flight are dropped.
//   The receiver cannot stall the result channel, so none is needed.
// ----------------------------------------------------------------------------
module rational_to_binary64_rounder_unit
  import r2b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [63:0]      in_numerator_low,
  input  logic [31:0]      in_numerator_high,
  input  logic [DEN_W-1:0] in_denominator,
  output logic             out_valid,
  output logic [RES_W-1:0] out_result_bits,
  output logic             out_failed
);

  logic in_accept;
  logic front_vld;
  div_t front_data;
  logic [DIV_STAGES:0] dv_vld;
  div_t                dv_data [DIV_STAGES+1];

  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  r2b_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_accept),
    .in_num   ({in_numerator_high, in_numerator_low}),
    .in_den   (in_denominator),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  assign dv_vld[0]  = front_vld;
  assign dv_data[0] = front_data;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    r2b_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[g]),
      .in_data  (dv_data[g]),
      .out_vld  (dv_vld[g+1]),
      .out_data (dv_data[g+1])
    );
  end

  r2b_round u_round (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (dv_vld[DIV_STAGES]),
    .in_data         (dv_data[DIV_STAGES]),
    .out_valid       (out_valid),
    .out_result_bits (out_result_bits),
    .out_failed      (out_failed)
  );

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LATENCY))
    else $error("result without a matching transfer");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failed) |-> (out_result_bits == '0))
    else $error("failed result carries nonzero bits");

  a_normal_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_failed && out_result_bits != '0) |->
      (out_result_bits[RES_W-1:SIG_W-1] != '0))
    else $error("nonzero result has zero exponent field");

endmodule

@@ hw/rtl/r2b_front.sv @@
// ----------------------------------------------------------------------------
// r2b_front
// Two stages: bit lengths of both operands, then normalization, exponent
// estimate with its one-compare correction, and divider setup.
// ----------------------------------------------------------------------------
module r2b_front
  import r2b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_vld,
  output div_t             out_data
);

  logic              v1_r;
  logic [NUM_W-1:0]  n1_r;
  logic [DEN_W-1:0]  d1_r;
  logic [NLEN_W-1:0] nb1_r;
  logic [DLEN_W-1:0] db1_r;
  logic              v2_r;
  div_t              s2_r, s2_nxt;

  logic [NUM_W-1:0]  nn;
  logic [DEN_W-1:0]  dn;
  logic              lt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    n1_r  <= in_num;
    d1_r  <= in_den;
    nb1_r <= len_num(in_num);
    db1_r <= len_den(in_den);
    s2_r  <= s2_nxt;
  end

  always_comb begin
    nn = n1_r << (NLEN_W'(NUM_W) - nb1_r);
    dn = d1_r << (DLEN_W'(DEN_W) - db1_r);
    // quotient below one after alignment: drop the exponent by one
    lt = nn < {dn, {(NUM_W-DEN_W){1'b0}}};
    s2_nxt.div  = dn;
    s2_nxt.quo  = '0;
    s2_nxt.zero = (nb1_r == '0);
    s2_nxt.fail = (db1_r == '0);
    s2_nxt.expo = $signed(EXP_W'(nb1_r)) - $signed(EXP_W'(db1_r)) - $signed(EXP_W'(lt));
    if (lt) begin
      s2_nxt.rem  = nn[NUM_W-1:NUM_W-DEN_W];
      s2_nxt.feed = {nn[NUM_W-DEN_W-1:0], {(QB_W-(NUM_W-DEN_W)){1'b0}}};
    end else begin
      s2_nxt.rem  = {1'b0, nn[NUM_W-1:NUM_W-DEN_W+1]};
      s2_nxt.feed = {nn[NUM_W-DEN_W:0], {(QB_W-(NUM_W-DEN_W+1)){1'b0}}};
    end
  end

  assign out_vld  = v2_r;
  assign out_data = s2_r;

endmodule

@@ hw/rtl/r2b_div_stage.sv @@
// ----------------------------------------------------------------------------
// r2b_div_stage
// One register stage of the restoring divider, retiring STEPS quotient bits.
// ----------------------------------------------------------------------------
module r2b_div_stage
  import r2b_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  div_t in_data,
  output logic out_vld,
  output div_t out_data
);

  logic vld_r;
  div_t data_r, data_nxt;

  always_comb begin
    logic [DEN_W:0] trial;
    data_nxt = in_data;
    for (int j = 0; j < STEPS; j++) begin
      trial = {data_nxt.rem, data_nxt.feed[QB_W-1]};
      data_nxt.feed = {data_nxt.feed[QB_W-2:0], 1'b0};
      if (trial >= {1'b0, data_nxt.div}) begin
        data_nxt.rem = DEN_W'(trial - {1'b0, data_nxt.div});
        data_nxt.quo = {data_nxt.quo[QB_W-2:0], 1'b1};
      end else begin
        data_nxt.rem = trial[DEN_W-1:0];
        data_nxt.quo = {data_nxt.quo[QB_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

@@ hw/rtl/r2b_round.sv @@
// ----------------------------------------------------------------------------
// r2b_round
// Round to nearest even from the round bit and remainder, fix the carry out
// of the significand and pack the binary64 pattern.
// ----------------------------------------------------------------------------
module r2b_round
  import r2b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  div_t             in_data,
  output logic             out_valid,
  output logic [RES_W-1:0] out_result_bits,
  output logic             out_failed
);

  logic             vld_r;
  logic [RES_W-1:0] res_r, res_nxt;
  logic             fail_r;

  logic [SIG_W-1:0]  qm;
  logic              inc;
  logic [SIG_W:0]    qs;
  logic [EXPF_W-1:0] efield;

  always_comb begin
    qm  = in_data.quo[QB_W-1:1];
    // round bit set and either a sticky remainder or an odd significand
    inc = in_data.quo[0] & ((in_data.rem != '0) | qm[0]);
    qs  = {1'b0, qm} + {{SIG_W{1'b0}}, inc};
    efield = EXPF_W'($signed({{(EXPF_W-EXP_W){in_data.expo[EXP_W-1]}}, in_data.expo})
             + $signed(EXPF_W'(EXP_BIAS))) + {{(EXPF_W-1){1'b0}}, qs[SIG_W]};
    if (in_data.fail || in_data.zero) res_nxt = '0;
    else res_nxt = {efield, qs[SIG_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    fail_r <= in_data.fail;
  end

  assign out_valid       = vld_r;
  assign out_result_bits = res_r;
  assign out_failed      = fail_r;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives random and corner-case numerator/denominator pairs into the rational
// to binary64 rounder and checks every returned bit pattern and failure flag
// against a behavioral division with round to nearest, ties to even.
// ----------------------------------------------------------------------------
module tb;
  import r2b_pkg::*;

  typedef struct {
    logic [63:0]      nlo;
    logic [31:0]      nhi;
    logic [DEN_W-1:0] den;
  } quot_item_t;

  typedef struct {
    logic [RES_W-1:0] bits;
    logic             failed;
  } quot_result_t;

  localparam int WATCHDOG = 20000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [63:0]      in_numerator_low;
  logic [31:0]      in_numerator_high;
  logic [DEN_W-1:0] in_denominator;
  logic             out_valid;
  logic [RES_W-1:0] out_result_bits;
  logic             out_failed;

  quot_item_t   pending_q[$];
  quot_result_t expected_q[$];
  int           mismatches;
  int           checked;
  int           failures_seen;
  int           idle_cycles;
  int           burst_left;
  int           gap_left;
  bit           hold_for_drain;
  bit           drain_done;
  bit           stim_done;

  rational_to_binary64_rounder_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_numerator_low(in_numerator_low), .in_numerator_high(in_numerator_high),
    .in_denominator(in_denominator), .out_valid(out_valid),
    .out_result_bits(out_result_bits), .out_failed(out_failed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Integer division to a 53-bit quotient on 256-bit integers, then round on the remainder.
  function automatic quot_result_t predict_quotient(quot_item_t it);
    quot_result_t r;
    logic [255:0] n, d, sn, sd, q, rem, twice;
    int nb, db, e, sh;
    logic [52:0] sig;
    r.bits = '0;
    r.failed = 1'b0;
    n = {160'b0, it.nhi, it.nlo};
    d = {193'b0, it.den};
    if (d == 0) begin
      r.failed = 1'b1;
      return r;
    end
    if (n == 0) return r;
    nb = 0;
    db = 0;
    for (int i = 0; i < 96; i++) if (n[i]) nb = i + 1;
    for (int i = 0; i < 63; i++) if (d[i]) db = i + 1;
    e = nb - db;
    if (e >= 0) begin
      if (n < (d << e)) e--;
    end else if ((n << (-e)) < d) e--;
    sh = 52 - e;
    sn = n;
    sd = d;
    if (sh >= 0) sn = n << sh;
    else sd = d << (-sh);
    q = sn / sd;
    rem = sn % sd;
    twice = rem << 1;
    sig = q[52:0];
    if (twice > sd || (twice == sd && sig[0])) begin
      if (sig == 53'h1F_FFFF_FFFF_FFFF) begin
        sig = 53'h10_0000_0000_0000;
        e++;
      end else sig = sig + 1;
    end
    if (e < -1022 || e > 1023) begin
      r.failed = 1'b1;
      return r;
    end
    r.bits = {11'(e + EXP_BIAS), sig[51:0]};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value with a random bit length, so exponents spread widely.
  function automatic logic [127:0] rand_len(int maxw);
    logic [127:0] v;
    int w;
    w = $urandom_range(maxw, 1);
    v = {rand64(), rand64()};
    v = v & ((128'd1 << w) - 1);
    v[w-1] = 1'b1;
    return v;
  endfunction

  task automatic push_item(logic [95:0] n, logic [DEN_W-1:0] d);
    quot_item_t it;
    it.nlo = n[63:0];
    it.nhi = n[95:64];
    it.den = d;
    pending_q.push_back(it);
  endtask

  initial begin
    logic [127:0] nv, dv;
    logic [95:0]  nmax;
    logic [62:0]  dmax;
    nmax = '1;
    dmax = '1;
    push_item(96'd0, 63'd0);
    push_item(96'd5, 63'd0);
    push_item(nmax, 63'd0);
    push_item(96'd0, 63'd7);
    push_item(96'd1, 63'd1);
    push_item(nmax, 63'd1);
    push_item(96'd1, dmax);
    push_item(nmax, dmax);
    push_item(96'd1, 63'd3);
    push_item(96'd2, 63'd3);
    push_item(96'd10, 63'd3);
    push_item(96'd1, 63'd10);
    push_item(96'h1F_FFFF_FFFF_FFFF_F, 63'd16);
    push_item(96'h3F_FFFF_FFFF_FFFF_F, 63'd2);
    push_item(96'h20_0000_0000_0001, 63'd1);
    push_item(96'h20_0000_0000_0003, 63'd1);
    push_item(96'h40_0000_0000_0001, 63'd4);
    push_item(nmax, 63'h4000_0000_0000_0000);
    push_item({32'hFFFF_FFFF, 64'h0}, 63'h7FFF_FFFF_FFFF_FFFE);
    push_item(96'd12345, 63'd12345);
    for (int k = 0; k < 1850; k++) begin
      case ($urandom_range(9, 0))
        0: push_item({$urandom, rand64()}, 63'(rand64()));
        1: push_item({$urandom, rand64()}, 63'($urandom_range(3, 0)));
        2: begin
          // exact or near-tie: integer times denominator plus small offset
          dv = rand_len(30);
          nv = rand_len(60) * dv + $urandom_range(2, 0);
          push_item(nv[95:0], dv[62:0]);
        end
        default: begin
          nv = rand_len(96);
          dv = rand_len(63);
          push_item(nv[95:0], dv[62:0]);
        end
      endcase
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: bursts and gaps, with one full drain pause mid-run.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_numerator_low <= '0;
      in_numerator_high <= '0;
      in_denominator <= '0;
      burst_left <= 0;
      gap_left <= 0;
      hold_for_drain <= 1'b0;
      drain_done <= 1'b0;
      stim_done <= 1'b0;
    end else begin
      logic go;
      if (start && !busy) expected_q.push_back(predict_quotient(
          '{nlo: in_numerator_low, nhi: in_numerator_high, den: in_denominator}));
      go = 1'b0;
      if (!drain_done && pending_q.size() <= 925 && !(start && busy)) begin
        // pause once until the pipeline is empty
        hold_for_drain <= 1'b1;
        drain_done <= 1'b1;
      end else if (hold_for_drain) begin
        if (expected_q.size() == 0 && !start) hold_for_drain <= 1'b0;
      end else if (start && busy) begin
        go = 1'b1;
      end else if (pending_q.size() == 0) begin
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        go = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else burst_left <= burst_left - 1;
      end
      if (go && !(start && busy)) begin
        quot_item_t it;
        it = pending_q.pop_front();
        in_numerator_low <= it.nlo;
        in_numerator_high <= it.nhi;
        in_denominator <= it.den;
      end
      start <= go;
    end
  end

  // Monitor: compare each result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches <= 0;
      checked <= 0;
      failures_seen <= 0;
      idle_cycles <= 0;
    end else begin
      idle_cycles <= ((start && !busy) || out_valid) ? 0 : idle_cycles + 1;
      if (out_valid) begin
        quot_result_t ex;
        checked <= checked + 1;
        if (out_failed) failures_seen <= failures_seen + 1;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h failed=%b",
                                        out_result_bits, out_failed);
          mismatches <= mismatches + 1;
        end else begin
          ex = expected_q.pop_front();
          if (ex.bits !== out_result_bits || ex.failed !== out_failed) begin
            if (mismatches < 10)
              $display("mismatch: expected %h failed=%b, got %h failed=%b",
                       ex.bits, ex.failed, out_result_bits, out_failed);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && expected_q.size() == 0 && !start) && idle_cycles < WATCHDOG)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("TEST FAILED");
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      $display("checked %0d quotients (%0d flagged failed), %0d mismatches",
               checked, failures_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
    end
    $finish;
  end

endmodule
